// File: hdl/pcc_pkg.sv
`timescale 1ns / 1ps

package pcc_pkg;

   localparam logic [8:0] NO_PULSE_CODE = 9'd444;
   localparam logic [8:0] INVALID_PULSE = 9'd300;
   localparam logic [3:0] LOCO_POSITION = 4'd8;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HARD_BRADY_LIMIT   = 3'd0,
      CSR_BRADY_LIMIT        = 3'd1,
      CSR_TACHY_FLOOR        = 3'd2,
      CSR_HARD_TACHY_LIMIT   = 3'd3,
      CSR_START_PULSE_OFFSET = 3'd4,
      CSR_START_WINDOW_TICKS = 3'd5,
      CSR_REPEATS_TO_SWITCH  = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      COND_NONE     = 3'd0,
      COND_NORMAL   = 3'd1,
      COND_LIGHT    = 3'd2,
      COND_HARD     = 3'd3,
      COND_ASYSTOLE = 3'd4
   } cond_type;

   localparam logic [8:0]  HARD_BRADY_RESET   = 9'd40;
   localparam logic [8:0]  BRADY_RESET        = 9'd50;
   localparam logic [8:0]  TACHY_FLOOR_RESET  = 9'd100;
   localparam logic [8:0]  HARD_TACHY_RESET   = 9'd150;
   localparam logic [7:0]  START_OFFSET_RESET = 8'd20;
   localparam logic [15:0] START_WINDOW_RESET = 16'd60;
   localparam logic [7:0]  REPEATS_RESET      = 8'd3;

   typedef struct packed {
      logic [8:0]  hard_brady_limit;
      logic [8:0]  brady_limit;
      logic [8:0]  tachy_floor;
      logic [8:0]  hard_tachy_limit;
      logic [7:0]  start_pulse_offset;
      logic [15:0] start_window_ticks;
      logic [7:0]  repeats_to_switch;
   } cfg_type;

   typedef struct packed {
      logic [31:0] locomotion_mark;
      logic [9:0]  tachy_threshold;
      logic [7:0]  normal_count;
      logic [7:0]  light_count;
      logic [7:0]  hard_count;
      logic [7:0]  asystole_count;
      cond_type    reported_state;
   } state_type;

   typedef struct packed {
      logic [8:0]  pulse_rate;
      logic        walking;
      logic        running;
      logic [3:0]  body_position;
      logic [31:0] now_tick;
      logic [8:0]  recovery_level;
      logic [8:0]  displayed_pulse;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  condition;
      logic [9:0]  tachy_threshold_out;
      logic        start_write;
      logic [9:0]  start_pulse_value;
      logic [31:0] start_time_value;
   } rsp_payload_type;

endpackage

// File: hdl/pcc_stream_if.sv
`timescale 1ns / 1ps

interface pcc_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/pcc_step.sv
`timescale 1ns / 1ps

module pcc_step (
   input  pcc_pkg::cfg_type         cfg,
   input  pcc_pkg::state_type       state,
   input  pcc_pkg::req_payload_type item,
   output pcc_pkg::state_type       state_in,
   output pcc_pkg::rsp_payload_type result
);
   import pcc_pkg::*;

   // Counters hold at the top so that a compare against any repeat count stays exact.
   function automatic logic [7:0] sat_inc(input logic [7:0] value);
      sat_inc = (value == 8'hFF) ? value : value + 8'd1;
   endfunction

   logic        locomotion;
   logic [9:0]  sum;
   logic [31:0] idle;
   logic        in_window;
   logic [9:0]  raw_threshold;
   logic [9:0]  threshold;
   logic        write_start;
   logic [31:0] mark_next;
   cond_type    cls;
   logic [7:0]  normal_next;
   logic [7:0]  light_next;
   logic [7:0]  hard_next;
   logic [7:0]  asystole_next;
   logic [7:0]  repeats;

   assign locomotion = item.walking || item.running || (item.body_position == LOCO_POSITION);
   assign sum        = {1'b0, item.displayed_pulse} + {2'b00, cfg.start_pulse_offset};
   assign idle       = item.now_tick - state.locomotion_mark;
   assign in_window  = idle < {16'd0, cfg.start_window_ticks};
   assign threshold  = (raw_threshold < {1'b0, cfg.tachy_floor}) ?
                       {1'b0, cfg.tachy_floor} : raw_threshold;
   assign repeats    = cfg.repeats_to_switch;

   always_comb begin
      raw_threshold = state.tachy_threshold;
      write_start   = 1'b0;
      mark_next     = state.locomotion_mark;
      priority if (locomotion) begin
         mark_next = item.now_tick;
         if (item.displayed_pulse != NO_PULSE_CODE) begin
            raw_threshold = sum;
         end
      end else if (in_window) begin
         raw_threshold = sum;
         write_start   = 1'b1;
      end else begin
         raw_threshold = {1'b0, item.recovery_level};
      end
   end

   always_comb begin
      priority if (item.pulse_rate == 9'd0) begin
         cls = COND_ASYSTOLE;
      end else if (item.pulse_rate < cfg.hard_brady_limit) begin
         cls = COND_HARD;
      end else if (item.pulse_rate < cfg.brady_limit) begin
         cls = COND_LIGHT;
      end else if (item.pulse_rate < INVALID_PULSE) begin
         if ({1'b0, item.pulse_rate} > threshold) begin
            cls = (item.pulse_rate > cfg.hard_tachy_limit) ? COND_HARD : COND_LIGHT;
         end else begin
            cls = COND_NORMAL;
         end
      end else begin
         cls = COND_NONE;
      end
   end

   assign asystole_next = (cls == COND_ASYSTOLE) ? sat_inc(state.asystole_count) : 8'd0;
   assign hard_next     = (cls == COND_HARD) ? sat_inc(state.hard_count) : 8'd0;
   assign light_next    = (cls == COND_LIGHT) ? sat_inc(state.light_count) : 8'd0;
   assign normal_next   = (cls == COND_NONE || cls == COND_NORMAL) ?
                          sat_inc(state.normal_count) : 8'd0;

   always_comb begin
      state_in.locomotion_mark = mark_next;
      state_in.tachy_threshold = threshold;
      state_in.asystole_count  = asystole_next;
      state_in.hard_count      = hard_next;
      state_in.light_count     = light_next;
      state_in.normal_count    = normal_next;
      state_in.reported_state  = state.reported_state;
      priority if (light_next >= repeats) begin
         state_in.light_count    = repeats;
         state_in.reported_state = COND_LIGHT;
      end else if (hard_next >= repeats) begin
         state_in.hard_count     = repeats;
         state_in.reported_state = COND_HARD;
      end else if (asystole_next >= repeats) begin
         state_in.asystole_count = repeats;
         state_in.reported_state = COND_ASYSTOLE;
      end else if (normal_next >= repeats) begin
         state_in.normal_count   = repeats;
         state_in.reported_state = COND_NORMAL;
      end else begin
         state_in.reported_state = state.reported_state;
      end
   end

   assign result.condition           = state_in.reported_state;
   assign result.tachy_threshold_out = threshold;
   assign result.start_write         = write_start;
   assign result.start_pulse_value   = write_start ? sum : 10'd0;
   assign result.start_time_value    = write_start ? item.now_tick : 32'd0;

endmodule

// File: hdl/pulse_condition_classifier.sv
`timescale 1ns / 1ps
// Each reading is held in the input register and its result in the result register.
// Throughput: one reading per cycle while results are taken; the input and result registers each hold one item.
// A stalled result stops the input only once both the input and result registers are full.
// Synchronous reset clears the valid flags and the classifier state and loads the
// configuration registers with their default values.

module pulse_condition_classifier (
   input  logic                               clock,
   input  logic                               reset,
   pcc_stream_if.sink                         req_chan,
   pcc_stream_if.source                       rsp_chan,
   input  logic                               csr_write_enable,
   input  logic [pcc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pcc_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import pcc_pkg::*;

   cfg_type         cfg_ff;
   state_type       state_ff;
   state_type       state_in;
   req_payload_type in_ff;
   logic            in_valid_ff;
   rsp_payload_type rsp_ff;
   rsp_payload_type rsp_in;
   logic            rsp_valid_ff;
   logic            out_free;
   logic            advance;

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign advance        = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || advance;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   pcc_step u_step (
      .cfg      (cfg_ff),
      .state    (state_ff),
      .item     (in_ff),
      .state_in (state_in),
      .result   (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hard_brady_limit   <= HARD_BRADY_RESET;
         cfg_ff.brady_limit        <= BRADY_RESET;
         cfg_ff.tachy_floor        <= TACHY_FLOOR_RESET;
         cfg_ff.hard_tachy_limit   <= HARD_TACHY_RESET;
         cfg_ff.start_pulse_offset <= START_OFFSET_RESET;
         cfg_ff.start_window_ticks <= START_WINDOW_RESET;
         cfg_ff.repeats_to_switch  <= REPEATS_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_HARD_BRADY_LIMIT:   cfg_ff.hard_brady_limit   <= csr_write_data[8:0];
            CSR_BRADY_LIMIT:        cfg_ff.brady_limit        <= csr_write_data[8:0];
            CSR_TACHY_FLOOR:        cfg_ff.tachy_floor        <= csr_write_data[8:0];
            CSR_HARD_TACHY_LIMIT:   cfg_ff.hard_tachy_limit   <= csr_write_data[8:0];
            CSR_START_PULSE_OFFSET: cfg_ff.start_pulse_offset <= csr_write_data[7:0];
            CSR_START_WINDOW_TICKS: cfg_ff.start_window_ticks <= csr_write_data[15:0];
            CSR_REPEATS_TO_SWITCH:  cfg_ff.repeats_to_switch  <= csr_write_data[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.locomotion_mark <= 32'd0;
         state_ff.tachy_threshold <= {1'b0, TACHY_FLOOR_RESET};
         state_ff.normal_count    <= 8'd0;
         state_ff.light_count     <= 8'd0;
         state_ff.hard_count      <= 8'd0;
         state_ff.asystole_count  <= 8'd0;
         state_ff.reported_state  <= COND_NONE;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (out_free) begin
            rsp_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_ff <= req_chan.payload;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

`ifndef SYNTHESIS
   a_advance_fills_output: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("Result register empty after a reading moved forward.");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("Classifier state changed without a reading.");

   a_one_counter_active: assert property (@(posedge clock) disable iff (reset)
      $countones({state_ff.normal_count != 8'd0, state_ff.light_count != 8'd0,
                  state_ff.hard_count != 8'd0, state_ff.asystole_count != 8'd0}) <= 1)
      else $error("More than one repeat counter is running.");

   a_quiet_start_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.start_write |->
         rsp_ff.start_pulse_value == 10'd0 && rsp_ff.start_time_value == 32'd0)
      else $error("Start fields set without a start write.");
`endif

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import pcc_pkg::*;

   class condition_scoreboard;
      cfg_type         cfg;
      logic [31:0]     loco_mark;
      logic [9:0]      threshold;
      int unsigned     normal_run, light_run, hard_run, asystole_run;
      cond_type        reported;
      rsp_payload_type expected_q[$];
      int              errors, readings, checked, start_writes;
      bit [7:0]        seen_conditions;

      function new();
         cfg.hard_brady_limit   = HARD_BRADY_RESET;
         cfg.brady_limit        = BRADY_RESET;
         cfg.tachy_floor        = TACHY_FLOOR_RESET;
         cfg.hard_tachy_limit   = HARD_TACHY_RESET;
         cfg.start_pulse_offset = START_OFFSET_RESET;
         cfg.start_window_ticks = START_WINDOW_RESET;
         cfg.repeats_to_switch  = REPEATS_RESET;
         loco_mark = '0;
         threshold = 10'(TACHY_FLOOR_RESET);
         normal_run = 0;
         light_run = 0;
         hard_run = 0;
         asystole_run = 0;
         reported = COND_NONE;
      endfunction

      function void set_register(csr_index_type idx, logic [15:0] data);
         case (idx)
            CSR_HARD_BRADY_LIMIT:   cfg.hard_brady_limit   = data[8:0];
            CSR_BRADY_LIMIT:        cfg.brady_limit        = data[8:0];
            CSR_TACHY_FLOOR:        cfg.tachy_floor        = data[8:0];
            CSR_HARD_TACHY_LIMIT:   cfg.hard_tachy_limit   = data[8:0];
            CSR_START_PULSE_OFFSET: cfg.start_pulse_offset = data[7:0];
            CSR_START_WINDOW_TICKS: cfg.start_window_ticks = data;
            CSR_REPEATS_TO_SWITCH:  cfg.repeats_to_switch  = data[7:0];
            default: ;
         endcase
      endfunction

      // Advances the classifier by one accepted reading and queues the result it must produce.
      function void note_reading(req_payload_type rd);
         logic [9:0]      sum;
         logic [31:0]     idle;
         cond_type        cls;
         int unsigned     lim;
         rsp_payload_type want;

         want = '0;
         sum = 10'(rd.displayed_pulse) + 10'(cfg.start_pulse_offset);
         if (rd.walking || rd.running || rd.body_position == LOCO_POSITION) begin
            loco_mark = rd.now_tick;
            if (rd.displayed_pulse != NO_PULSE_CODE) threshold = sum;
         end else begin
            idle = rd.now_tick - loco_mark;
            if (idle < 32'(cfg.start_window_ticks)) begin
               threshold = sum;
               want.start_write = 1'b1;
               want.start_pulse_value = sum;
               want.start_time_value = rd.now_tick;
               start_writes++;
            end else begin
               threshold = 10'(rd.recovery_level);
            end
         end
         if (threshold < 10'(cfg.tachy_floor)) threshold = 10'(cfg.tachy_floor);

         if (rd.pulse_rate == 9'd0) begin
            cls = COND_ASYSTOLE;
         end else if (rd.pulse_rate < cfg.hard_brady_limit) begin
            cls = COND_HARD;
         end else if (rd.pulse_rate < cfg.brady_limit) begin
            cls = COND_LIGHT;
         end else if (rd.pulse_rate < INVALID_PULSE) begin
            if (10'(rd.pulse_rate) > threshold)
               cls = (rd.pulse_rate > cfg.hard_tachy_limit) ? COND_HARD : COND_LIGHT;
            else
               cls = COND_NORMAL;
         end else begin
            cls = COND_NONE;
         end

         asystole_run = (cls == COND_ASYSTOLE) ? asystole_run + 1 : 0;
         hard_run     = (cls == COND_HARD) ? hard_run + 1 : 0;
         light_run    = (cls == COND_LIGHT) ? light_run + 1 : 0;
         normal_run   = (cls == COND_NONE || cls == COND_NORMAL) ? normal_run + 1 : 0;

         lim = 32'(cfg.repeats_to_switch);
         if (light_run >= lim) begin
            light_run = lim;
            reported = COND_LIGHT;
         end else if (hard_run >= lim) begin
            hard_run = lim;
            reported = COND_HARD;
         end else if (asystole_run >= lim) begin
            asystole_run = lim;
            reported = COND_ASYSTOLE;
         end else if (normal_run >= lim) begin
            normal_run = lim;
            reported = COND_NORMAL;
         end

         want.condition = reported;
         want.tachy_threshold_out = threshold;
         expected_q.push_back(want);
         readings++;
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(rsp_payload_type got);
         rsp_payload_type want;

         if (expected_q.size() == 0) begin
            $error("result transfer with no reading outstanding");
            errors++;
            return;
         end
         want = expected_q.pop_front();
         checked++;
         if (!$isunknown(got.condition)) seen_conditions[got.condition] = 1'b1;
         compare_field("condition", 32'(want.condition), 32'(got.condition));
         compare_field("tachy_threshold_out", 32'(want.tachy_threshold_out),
                       32'(got.tachy_threshold_out));
         compare_field("start_write", 32'(want.start_write), 32'(got.start_write));
         compare_field("start_pulse_value", 32'(want.start_pulse_value),
                       32'(got.start_pulse_value));
         compare_field("start_time_value", want.start_time_value, got.start_time_value);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic          clock;
   logic          reset;
   logic          csr_write_enable;
   csr_index_type csr_index;
   logic [15:0]   csr_write_data;

   pcc_stream_if #(.payload_type(req_payload_type)) req_if ();
   pcc_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   pulse_condition_classifier DUT (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   condition_scoreboard sb = new();

   logic [31:0] tick;
   bit          in_loco;
   int          loco_left;
   int          band;
   int          band_left;
   int          send_quiet;
   int          recv_quiet;
   int          settings_done;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic int draw_wait(inout int quiet);
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         quiet = $urandom_range(10, 50);
         return 0;
      end
      return $urandom_range(0, 15);
   endfunction

   function automatic req_payload_type make_reading(int pulse, bit walk, bit run, int pos,
                                                    logic [31:0] now, int level, int shown);
      req_payload_type rd;

      rd.pulse_rate      = 9'(pulse);
      rd.walking         = walk;
      rd.running         = run;
      rd.body_position   = 4'(pos);
      rd.now_tick        = now;
      rd.recovery_level  = 9'(level);
      rd.displayed_pulse = 9'(shown);
      return rd;
   endfunction

   function automatic logic [3:0] idle_position();
      int p;

      p = $urandom_range(0, 14);
      return 4'((p >= 8) ? p + 1 : p);
   endfunction

   function automatic req_payload_type next_reading();
      req_payload_type rd;
      int              lo, hi, roll;
      logic [2:0]      combo;

      if (band_left == 0) begin
         band = $urandom_range(0, 5);
         band_left = $urandom_range(1, int'(sb.cfg.repeats_to_switch) + 3);
      end
      band_left--;
      case (band)
         0: begin lo = 0; hi = 0; end
         1: begin lo = 1; hi = int'(sb.cfg.hard_brady_limit) - 1; end
         2: begin lo = int'(sb.cfg.hard_brady_limit); hi = int'(sb.cfg.brady_limit) - 1; end
         3: begin
            lo = int'(sb.cfg.brady_limit);
            hi = (sb.threshold < 10'd299) ? int'(sb.threshold) : 299;
         end
         4: begin lo = int'(sb.threshold) + 1; hi = 299; end
         default: begin lo = 300; hi = 511; end
      endcase
      if (lo > hi || $urandom_range(0, 9) == 0)
         rd.pulse_rate = 9'($urandom_range(0, 511));
      else
         rd.pulse_rate = 9'($urandom_range(hi, lo));

      roll = $urandom_range(0, 99);
      if (roll == 0)
         tick = $urandom;
      else if (roll < 3)
         tick = tick + $urandom_range(0, 131071);
      else
         tick = tick + $urandom_range(0, 2);
      rd.now_tick = tick;

      if (loco_left == 0) begin
         in_loco = !in_loco;
         loco_left = in_loco ? $urandom_range(1, 8) : $urandom_range(1, 50);
      end
      loco_left--;
      if ($urandom_range(0, 39) == 0) begin
         rd.walking = 1'($urandom_range(0, 1));
         rd.running = 1'($urandom_range(0, 1));
         rd.body_position = 4'($urandom_range(0, 15));
      end else if (in_loco) begin
         combo = 3'($urandom_range(1, 7));
         rd.walking = combo[0];
         rd.running = combo[1];
         rd.body_position = combo[2] ? LOCO_POSITION : idle_position();
      end else begin
         rd.walking = 1'b0;
         rd.running = 1'b0;
         rd.body_position = idle_position();
      end

      rd.recovery_level = 9'($urandom_range(0, 511));
      rd.displayed_pulse = ($urandom_range(0, 7) == 0) ? NO_PULSE_CODE
                                                        : 9'($urandom_range(0, 511));
      return rd;
   endfunction

   task automatic send_reading(input req_payload_type rd);
      int gap;

      gap = draw_wait(send_quiet);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.payload <= rd;
      do @(negedge clock); while (!req_if.ready);
      @(posedge clock);
      sb.note_reading(rd);
   endtask

   // Holds off the sender until every outstanding result has been taken.
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [15:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      sb.set_register(idx, data);
   endtask

   task automatic write_settings(input logic [15:0] hard_brady, input logic [15:0] brady,
                                 input logic [15:0] floor, input logic [15:0] hard_tachy,
                                 input logic [15:0] offset, input logic [15:0] window,
                                 input logic [15:0] repeats);
      wait_idle();
      write_register(CSR_HARD_BRADY_LIMIT, hard_brady);
      write_register(CSR_BRADY_LIMIT, brady);
      write_register(CSR_TACHY_FLOOR, floor);
      write_register(CSR_HARD_TACHY_LIMIT, hard_tachy);
      write_register(CSR_START_PULSE_OFFSET, offset);
      write_register(CSR_START_WINDOW_TICKS, window);
      write_register(CSR_REPEATS_TO_SWITCH, repeats);
      csr_write_enable <= 1'b0;
      settings_done++;
   endtask

   initial begin
      rsp_payload_type got;
      int              stall;

      do @(posedge clock); while (reset);
      forever begin
         stall = draw_wait(recv_quiet);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(negedge clock); while (!rsp_if.valid);
         got = rsp_if.payload;
         @(posedge clock);
         sb.check_result(got);
      end
   end

   initial begin
      logic [31:0] t0;
      int          hb, br, fl;

      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.payload <= '0;
      rsp_if.ready <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_index <= CSR_HARD_BRADY_LIMIT;
      csr_write_data <= '0;
      in_loco = 1'b0;
      loco_left = 0;
      band_left = 0;
      send_quiet = 0;
      recv_quiet = 0;
      settings_done = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed readings under the reset settings; the first start window crosses the
      // tick wrap, and the window edge is hit one tick inside and exactly at its length.
      t0 = 32'hFFFF_FFF0;
      send_reading(make_reading(0,   1, 0, 0,  t0,        0,   444));
      send_reading(make_reading(0,   0, 1, 3,  t0 + 1,    511, 80));
      send_reading(make_reading(0,   0, 0, 8,  t0 + 2,    0,   511));
      send_reading(make_reading(1,   0, 0, 0,  t0 + 32,   0,   444));
      send_reading(make_reading(39,  0, 0, 15, t0 + 40,   0,   0));
      send_reading(make_reading(20,  0, 0, 7,  t0 + 59,   0,   300));
      send_reading(make_reading(40,  1, 1, 8,  t0 + 60,   0,   100));
      send_reading(make_reading(49,  0, 0, 9,  t0 + 119,  0,   200));
      send_reading(make_reading(45,  0, 0, 1,  t0 + 120,  511, 200));
      send_reading(make_reading(50,  0, 0, 2,  t0 + 200,  0,   200));
      send_reading(make_reading(100, 0, 0, 4,  t0 + 201,  0,   0));
      send_reading(make_reading(101, 0, 0, 4,  t0 + 202,  0,   0));
      send_reading(make_reading(299, 0, 0, 4,  t0 + 203,  298, 0));
      send_reading(make_reading(151, 0, 0, 5,  t0 + 204,  150, 0));
      send_reading(make_reading(150, 0, 0, 6,  t0 + 205,  149, 0));
      send_reading(make_reading(300, 0, 0, 10, t0 + 206,  0,   0));
      send_reading(make_reading(511, 0, 0, 11, t0 + 207,  0,   0));
      send_reading(make_reading(256, 0, 0, 12, t0 + 208,  300, 0));
      send_reading(make_reading(77,  0, 0, 13, 32'h8000_0000, 0, 444));
      send_reading(make_reading(511, 1, 1, 15, 32'hFFFF_FFFF, 511, 511));
      send_reading(make_reading(85,  0, 0, 14, 32'hFFFF_FFFF, 255, 444));

      tick = $urandom;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            1: write_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1);
            2: write_settings(16'd511, 16'd511, 16'd511, 16'd511, 16'd255, 16'd65535,
                              16'd255);
            5: write_settings(16'(HARD_BRADY_RESET), 16'(BRADY_RESET),
                              16'(TACHY_FLOOR_RESET), 16'(HARD_TACHY_RESET),
                              16'(START_OFFSET_RESET), START_WINDOW_RESET,
                              16'(REPEATS_RESET));
            default: begin
               hb = $urandom_range(0, 200);
               br = $urandom_range(hb, 260);
               fl = $urandom_range(0, 300);
               write_settings(16'(hb), 16'(br), 16'(fl), 16'($urandom_range(fl, 320)),
                              16'($urandom_range(0, 255)), 16'($urandom_range(0, 200)),
                              16'($urandom_range(1, 6)));
            end
         endcase
         band_left = 0;
         for (int n = 0; n < 225; n++) begin
            if (n == 112) wait_idle();
            send_reading(next_reading());
         end
      end

      wait_idle();
      $display("Run covered %0d readings and %0d checked results over %0d register settings,",
               sb.readings, sb.checked, settings_done + 1);
      $display("with %0d start writes and reported conditions seen (bit per code) %b.",
               sb.start_writes, sb.seen_conditions[4:0]);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
